// ----- rtl/core/consistent_hash_ring_router_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the consistent hash ring router.
// Define ASSERT_OFF to compile every check away.
// ----------------------------------------------------------------------------
`ifndef CONSISTENT_HASH_RING_ROUTER_MACROS_SVH
`define CONSISTENT_HASH_RING_ROUTER_MACROS_SVH

`ifndef ASSERT_OFF
// Checked on every clock edge outside reset.
`define CHR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Checked on every clock edge, reset cycles included.
`define CHR_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CHR_ASSERT(lbl, prop, msg)
`define CHR_ASSERT_RST(lbl, prop, msg)
`endif

`endif

// ----- rtl/core/chr_pkg.sv -----
// ----------------------------------------------------------------------------
// chr_pkg
// Types and codes shared by the hash ring router controller and datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package chr_pkg;

  localparam logic [1:0] OP_BEGIN  = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;
  localparam logic [1:0] OP_LOOKUP = 2'd3;

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_PRESENT    = 3'd1;
  localparam logic [2:0] ST_FULL       = 3'd2;
  localparam logic [2:0] ST_NONE_FOUND = 3'd3;
  localparam logic [2:0] ST_EMPTY      = 3'd4;
  localparam logic [2:0] ST_NOT_BEGUN  = 3'd5;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [3:0]  node_index;
    logic [63:0] hash_value;
  } chr_req_t;

  typedef struct packed {
    logic [2:0] status;
    logic [3:0] routed_node;
  } chr_rsp_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_COMPACT,
    S_RESOLVE,
    S_RESP
  } chr_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic exec;
    logic compact;
    logic resolve;
    logic rsp_load;
  } chr_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [1:0] op;
    logic       settled;
    logic       out_free;
  } chr_stat_t;

endpackage

// ----- rtl/core/chr_datapath.sv -----
// ----------------------------------------------------------------------------
// chr_datapath
// Sorted chain of ring cells with parallel compare, shift and compaction,
// the node presence marks, and the response register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module chr_datapath #(
  parameter int RING_DEPTH = 64,
  parameter int NODE_COUNT = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  chr_pkg::chr_req_t  req,
  input  chr_pkg::chr_cmd_t  cmd,
  output chr_pkg::chr_stat_t stat,
  output chr_pkg::chr_rsp_t  rsp,
  output logic             rsp_valid,
  input  logic             rsp_stall
);

  localparam int NIDX_W = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;

  // Latched request.
  logic [1:0]  op_q;
  logic [3:0]  idx_q;
  logic [63:0] key_q;

  // Ring cells. Live entries form a prefix of the chain once compaction has settled.
  logic [63:0]           entry_hash [RING_DEPTH];
  logic [3:0]            entry_node [RING_DEPTH];
  logic [RING_DEPTH-1:0] live;

  logic [63:0]           hash_next [RING_DEPTH];
  logic [3:0]            node_next [RING_DEPTH];
  logic [RING_DEPTH-1:0] live_next;

  logic [NODE_COUNT-1:0] node_present;

  logic [RING_DEPTH-1:0] le;
  logic [RING_DEPTH-1:0] geq;
  logic [RING_DEPTH-1:0] match;
  logic [RING_DEPTH-2:0] hole;
  logic [RING_DEPTH-1:0] ge_q;
  logic [RING_DEPTH-1:0] sel;
  logic                  empty_q;
  logic                  phase;

  logic [31:0]       idx_ext;
  logic [NIDX_W-1:0] idx_sel;
  logic              idx_ok;
  logic              present;
  logic              insert_go;
  logic              remove_go;
  logic              compact_go;
  logic [3:0]        node_or;
  logic [3:0]        found_node;

  logic [2:0] res_status;
  logic [3:0] res_node;

  assign idx_ext = 32'(idx_q);
  assign idx_sel = idx_ext[NIDX_W-1:0];
  assign idx_ok  = idx_ext < 32'(NODE_COUNT);
  assign present = idx_ok && node_present[idx_sel];

  always_comb begin
    for (int k = 0; k < RING_DEPTH; k++) begin
      le[k]    = live[k] && (entry_hash[k] <= key_q);
      geq[k]   = live[k] && (entry_hash[k] >= key_q);
      match[k] = live[k] && (entry_node[k] == idx_q);
    end
    for (int k = 0; k < RING_DEPTH - 1; k++) begin
      hole[k] = !live[k] && live[k+1];
    end
  end

  assign insert_go  = cmd.exec && (op_q == chr_pkg::OP_INSERT) && present &&
                      !live[RING_DEPTH-1];
  assign remove_go  = cmd.exec && (op_q == chr_pkg::OP_REMOVE);
  assign compact_go = cmd.compact;

  always_comb begin
    for (int k = 0; k < RING_DEPTH; k++) begin
      hash_next[k] = entry_hash[k];
      node_next[k] = entry_node[k];
      live_next[k] = live[k];
    end
    if (insert_go) begin
      // The new entry lands on the first cell that is free or whose hash exceeds
      // the key; every cell after it takes its left neighbor.
      if (!le[0]) begin
        hash_next[0] = key_q;
        node_next[0] = idx_q;
        live_next[0] = 1'b1;
      end
      for (int k = 1; k < RING_DEPTH; k++) begin
        if (!le[k]) begin
          if (le[k-1]) begin
            hash_next[k] = key_q;
            node_next[k] = idx_q;
            live_next[k] = 1'b1;
          end else begin
            hash_next[k] = entry_hash[k-1];
            node_next[k] = entry_node[k-1];
            live_next[k] = live[k-1];
          end
        end
      end
    end else if (remove_go) begin
      live_next = live & ~match;
    end else if (compact_go) begin
      // Odd-even passes over disjoint cell pairs move live entries left
      // into holes without changing their order.
      for (int k = 0; k < RING_DEPTH - 1; k++) begin
        if ((1'(k % 2) == phase) && hole[k]) begin
          hash_next[k]   = entry_hash[k+1];
          node_next[k]   = entry_node[k+1];
          live_next[k]   = 1'b1;
          live_next[k+1] = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < RING_DEPTH; k++) begin
      entry_hash[k] <= hash_next[k];
      entry_node[k] <= node_next[k];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      live         <= '0;
      node_present <= '0;
      phase        <= 1'b0;
    end else begin
      live <= live_next;
      if (compact_go) begin
        phase <= !phase;
      end
      if (cmd.exec && (op_q == chr_pkg::OP_BEGIN) && idx_ok && !present) begin
        node_present[idx_sel] <= 1'b1;
      end
      if (remove_go && idx_ok) begin
        node_present[idx_sel] <= 1'b0;
      end
    end
  end

  // Sorted order makes the at-or-above marks a suffix of the live region,
  // so the first one is found without a priority chain.
  assign sel = ge_q & ~{ge_q[RING_DEPTH-2:0], 1'b0};

  always_comb begin
    node_or = '0;
    for (int k = 0; k < RING_DEPTH; k++) begin
      node_or = node_or | ({4{sel[k]}} & entry_node[k]);
    end
    found_node = (|ge_q) ? node_or : entry_node[0];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q  <= req.opcode;
      idx_q <= req.node_index;
      key_q <= req.hash_value;
    end
    if (cmd.exec) begin
      res_node <= '0;
      ge_q     <= geq;
      empty_q  <= !live[0];
      case (op_q)
        chr_pkg::OP_BEGIN: begin
          res_status <= present || !idx_ok ? chr_pkg::ST_PRESENT : chr_pkg::ST_OK;
        end
        chr_pkg::OP_INSERT: begin
          if (!present) begin
            res_status <= chr_pkg::ST_NOT_BEGUN;
          end else if (live[RING_DEPTH-1]) begin
            res_status <= chr_pkg::ST_FULL;
          end else begin
            res_status <= chr_pkg::ST_OK;
          end
        end
        chr_pkg::OP_REMOVE: begin
          res_status <= (|match) ? chr_pkg::ST_OK : chr_pkg::ST_NONE_FOUND;
        end
        default: begin
          res_status <= live[0] ? chr_pkg::ST_OK : chr_pkg::ST_EMPTY;
        end
      endcase
    end
    if (cmd.resolve) begin
      res_node <= empty_q ? 4'd0 : found_node;
    end
    if (cmd.rsp_load) begin
      rsp.status      <= res_status;
      rsp.routed_node <= res_node;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.rsp_load) begin
      rsp_valid <= 1'b1;
    end else if (rsp_valid && !rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  assign stat.op       = op_q;
  assign stat.settled  = !(|hole);
  assign stat.out_free = !rsp_valid || !rsp_stall;

endmodule

// ----- rtl/core/chr_ctrl.sv -----
// ----------------------------------------------------------------------------
// chr_ctrl
// Sequencer that steps one request at a time through the ring datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "consistent_hash_ring_router_macros.svh"

module chr_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_stall,
  input  chr_pkg::chr_stat_t stat,
  output chr_pkg::chr_cmd_t  cmd
);

  chr_pkg::chr_state_t state;
  chr_pkg::chr_state_t state_next;

  always_comb begin
    state_next = state;
    unique case (state)
      chr_pkg::S_IDLE: begin
        if (req_valid) begin
          state_next = chr_pkg::S_EXEC;
        end
      end
      chr_pkg::S_EXEC: begin
        if (stat.op == chr_pkg::OP_REMOVE) begin
          state_next = chr_pkg::S_COMPACT;
        end else if (stat.op == chr_pkg::OP_LOOKUP) begin
          state_next = chr_pkg::S_RESOLVE;
        end else begin
          state_next = chr_pkg::S_RESP;
        end
      end
      chr_pkg::S_COMPACT: begin
        if (stat.settled) begin
          state_next = chr_pkg::S_RESP;
        end
      end
      chr_pkg::S_RESOLVE: begin
        state_next = chr_pkg::S_RESP;
      end
      chr_pkg::S_RESP: begin
        if (stat.out_free) begin
          state_next = chr_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = chr_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd       = '0;
    req_stall = 1'b1;
    unique case (state)
      chr_pkg::S_IDLE: begin
        req_stall = 1'b0;
        cmd.load  = req_valid;
      end
      chr_pkg::S_EXEC: begin
        cmd.exec = 1'b1;
      end
      chr_pkg::S_COMPACT: begin
        cmd.compact = !stat.settled;
      end
      chr_pkg::S_RESOLVE: begin
        cmd.resolve = 1'b1;
      end
      chr_pkg::S_RESP: begin
        cmd.rsp_load = stat.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= chr_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  `CHR_ASSERT(a_accept_starts_exec, (req_valid && !req_stall) |=> (state == chr_pkg::S_EXEC), "accepted transfer did not start execution")
  `CHR_ASSERT(a_compact_only_remove, (state == chr_pkg::S_COMPACT) |-> (stat.op == chr_pkg::OP_REMOVE), "compaction entered for an operation other than remove")
  `CHR_ASSERT(a_resolve_after_exec, (state == chr_pkg::S_RESOLVE) |-> ($past(state) == chr_pkg::S_EXEC), "lookup resolve did not follow execution")
  `CHR_ASSERT_RST(a_reset_to_idle, rst |=> (state == chr_pkg::S_IDLE), "controller not idle after reset")

endmodule

// ----- rtl/core/consistent_hash_ring_router.sv -----
// ----------------------------------------------------------------------------
// consistent_hash_ring_router: sorted virtual-node ring with node routing.
// Each request steps through the execute and respond states; lookup adds a
// resolve step, and remove adds odd-even compaction passes until no hole is
// left. Throughput: one request at a time; the next transfer is taken only
// after the previous result is loaded, later while a result stalls.
// Synchronous reset empties the ring and clears all presence marks at once.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module consistent_hash_ring_router #(
  parameter int RING_DEPTH = 64,
  parameter int NODE_COUNT = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_stall,
  input  chr_pkg::chr_req_t req,
  output logic              rsp_valid,
  input  logic              rsp_stall,
  output chr_pkg::chr_rsp_t rsp
);

  chr_pkg::chr_cmd_t  cmd;
  chr_pkg::chr_stat_t stat;

  chr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  chr_datapath #(
    .RING_DEPTH (RING_DEPTH),
    .NODE_COUNT (NODE_COUNT)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd       (cmd),
    .stat      (stat),
    .rsp       (rsp),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall)
  );

endmodule

// ----- verif/tb_consistent_hash_ring_router.sv -----
// ----------------------------------------------------------------------------
// tb_consistent_hash_ring_router
// Self-checking testbench for the hash ring router. A table of directed
// requests runs first, then rounds of random traffic that grow the ring,
// fill it past capacity, churn it and drain it. Each result is checked against
// its typed table value or a model of the sorted ring, under random gaps and stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_consistent_hash_ring_router;

  localparam int RING_DEPTH  = 64;
  localparam int NODE_COUNT  = 16;
  localparam int ITEM_TARGET = 1400;
  localparam int IDLE_LIMIT  = 2000;
  localparam int DRAIN_WAIT  = 80;

  typedef struct packed {
    chr_pkg::chr_req_t req;
    logic              typed;
    chr_pkg::chr_rsp_t rsp;
  } dir_row_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              req_valid = 1'b0;
  logic              req_stall;
  chr_pkg::chr_req_t req = '0;
  logic              rsp_valid;
  logic              rsp_stall = 1'b0;
  chr_pkg::chr_rsp_t rsp;

  // Model of the ring contents.
  logic [63:0] ring_hash [RING_DEPTH];
  logic [3:0]  ring_node [RING_DEPTH];
  int          ring_count = 0;
  bit          node_live [NODE_COUNT];

  chr_pkg::chr_rsp_t route_expect [$];
  dir_row_t          plan [$];

  int  fail_count   = 0;
  int  sent_count   = 0;
  int  result_count = 0;
  int  full_seen    = 0;
  int  empty_seen   = 0;
  int  idle_cycles  = 0;
  bit  calm         = 1'b0;

  consistent_hash_ring_router #(
    .RING_DEPTH(RING_DEPTH),
    .NODE_COUNT(NODE_COUNT)
  ) u_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  always #10 clk = ~clk;

  // Computes the routing result of one request and updates the ring model.
  function automatic chr_pkg::chr_rsp_t route_predict(chr_pkg::chr_req_t r);
    chr_pkg::chr_rsp_t o;
    int                pos;
    int                wr;
    bit                hit;
    o.status      = chr_pkg::ST_OK;
    o.routed_node = '0;
    case (r.opcode)
      chr_pkg::OP_BEGIN: begin
        if (node_live[r.node_index]) o.status = chr_pkg::ST_PRESENT;
        else node_live[r.node_index] = 1'b1;
      end
      chr_pkg::OP_INSERT: begin
        if (!node_live[r.node_index]) begin
          o.status = chr_pkg::ST_NOT_BEGUN;
        end else if (ring_count >= RING_DEPTH) begin
          o.status = chr_pkg::ST_FULL;
          full_seen++;
        end else begin
          // Equal hashes keep arrival order: the new entry lands after them.
          pos = 0;
          while (pos < ring_count && ring_hash[pos] <= r.hash_value) pos++;
          for (int k = ring_count; k > pos; k--) begin
            ring_hash[k] = ring_hash[k-1];
            ring_node[k] = ring_node[k-1];
          end
          ring_hash[pos] = r.hash_value;
          ring_node[pos] = r.node_index;
          ring_count++;
        end
      end
      chr_pkg::OP_REMOVE: begin
        wr  = 0;
        hit = 1'b0;
        for (int rd = 0; rd < ring_count; rd++) begin
          if (ring_node[rd] == r.node_index) begin
            hit = 1'b1;
          end else begin
            ring_hash[wr] = ring_hash[rd];
            ring_node[wr] = ring_node[rd];
            wr++;
          end
        end
        ring_count = wr;
        node_live[r.node_index] = 1'b0;
        if (!hit) o.status = chr_pkg::ST_NONE_FOUND;
      end
      default: begin
        if (ring_count == 0) begin
          o.status = chr_pkg::ST_EMPTY;
          empty_seen++;
        end else begin
          pos = 0;
          while (pos < ring_count && ring_hash[pos] < r.hash_value) pos++;
          if (pos >= ring_count) pos = 0;
          o.routed_node = ring_node[pos];
        end
      end
    endcase
    return o;
  endfunction

  function automatic int draw_gap();
    return calm ? 0 : $urandom_range(0, 18);
  endfunction

  function automatic dir_row_t row(logic [1:0] op, logic [3:0] idx, logic [63:0] h,
                                   logic typed, logic [2:0] st, logic [3:0] node);
    dir_row_t d;
    d.req.opcode          = op;
    d.req.node_index      = idx;
    d.req.hash_value      = h;
    d.typed               = typed;
    d.rsp.status          = st;
    d.rsp.routed_node     = node;
    return d;
  endfunction

  // Hashes lean toward the extremes, toward values already on the ring and
  // toward a coarse grid, so that equal hashes and boundary lookups are common.
  function automatic logic [63:0] pick_hash(bit for_lookup);
    int          sel;
    logic [63:0] h;
    sel = $urandom_range(0, 99);
    if (sel < 8) begin
      h = '0;
    end else if (sel < 16) begin
      h = '1;
    end else if (sel < 46 && ring_count > 0) begin
      h = ring_hash[$urandom_range(0, ring_count - 1)];
      if (for_lookup) begin
        case ($urandom_range(0, 2))
          1: h = h + 64'd1;
          2: h = h - 64'd1;
          default: ;
        endcase
      end
    end else if (sel < 60) begin
      h = 64'($urandom_range(0, 31)) << 59;
    end else begin
      h = {$urandom, $urandom};
    end
    return h;
  endfunction

  function automatic logic [3:0] pick_node(bit want_live);
    logic [3:0] n;
    n = 4'($urandom_range(0, NODE_COUNT - 1));
    if (want_live) begin
      for (int t = 0; t < 16 && !node_live[n]; t++) n = 4'($urandom_range(0, NODE_COUNT - 1));
    end
    return n;
  endfunction

  function automatic chr_pkg::chr_req_t rand_req(int wb, int wi, int wr, int wl);
    chr_pkg::chr_req_t r;
    int                roll;
    roll = $urandom_range(0, wb + wi + wr + wl - 1);
    if (roll < wb) begin
      r.opcode     = chr_pkg::OP_BEGIN;
      r.node_index = pick_node(1'b0);
    end else if (roll < wb + wi) begin
      r.opcode     = chr_pkg::OP_INSERT;
      r.node_index = pick_node($urandom_range(0, 9) != 0);
    end else if (roll < wb + wi + wr) begin
      r.opcode     = chr_pkg::OP_REMOVE;
      r.node_index = pick_node($urandom_range(0, 3) != 0);
    end else begin
      r.opcode     = chr_pkg::OP_LOOKUP;
      r.node_index = pick_node(1'b0);
    end
    r.hash_value = pick_hash(r.opcode == chr_pkg::OP_LOOKUP);
    return r;
  endfunction

  // Presents one request and returns at the edge where it is taken.
  // Valid is only lowered when a gap follows, so it never toggles within a step.
  task automatic send(chr_pkg::chr_req_t r, bit typed, chr_pkg::chr_rsp_t typed_rsp);
    int                gap;
    chr_pkg::chr_rsp_t p;
    gap = draw_gap();
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= r;
    do @(posedge clk); while (req_stall);
    p = route_predict(r);
    route_expect = {route_expect, (typed ? typed_rsp : p)};
    sent_count++;
  endtask

  task automatic send_rand(int n, int wb, int wi, int wr, int wl);
    repeat (n) send(rand_req(wb, wi, wr, wl), 1'b0, '0);
  endtask

  task automatic settle();
    req_valid <= 1'b0;
    while (route_expect.size() != 0) @(posedge clk);
  endtask

  // Receiver: each result waits out a random stall before it is taken.
  initial begin
    int n;
    forever begin
      n = draw_gap();
      if (n > 0) begin
        rsp_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      rsp_stall <= 1'b0;
      do @(posedge clk); while (!rsp_valid);
    end
  end

  always @(posedge clk) begin
    chr_pkg::chr_rsp_t e;
    if (!rst && rsp_valid && !rsp_stall) begin
      result_count++;
      if (route_expect.size() == 0) begin
        $error("result with no request outstanding: status %0d node %0d",
               rsp.status, rsp.routed_node);
        fail_count++;
      end else begin
        e = route_expect.pop_front();
        if (rsp.status !== e.status) begin
          $error("status mismatch: expected %0d, actual %0d", e.status, rsp.status);
          fail_count++;
        end
        if (rsp.routed_node !== e.routed_node) begin
          $error("routed_node mismatch: expected %0d, actual %0d",
                 e.routed_node, rsp.routed_node);
          fail_count++;
        end
      end
    end
  end

  // Watchdog on cycles in which neither channel completes a transfer.
  always @(posedge clk) begin
    if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
               IDLE_LIMIT, route_expect.size());
      $display("FAIL consistent_hash_ring_router");
      $finish;
    end
  end

  initial begin
    dir_row_t d;
    int       rnd;

    plan = {plan, row(chr_pkg::OP_LOOKUP, 4'd0,  64'd0, 1'b1, chr_pkg::ST_EMPTY, 4'd0)};
    plan = {plan, row(chr_pkg::OP_LOOKUP, 4'd15, '1,    1'b1, chr_pkg::ST_EMPTY, 4'd0)};
    plan = {plan, row(chr_pkg::OP_REMOVE, 4'd0,  '1,    1'b1, chr_pkg::ST_NONE_FOUND,
                      4'd0)};
    plan = {plan, row(chr_pkg::OP_INSERT, 4'd15, 64'd0, 1'b1, chr_pkg::ST_NOT_BEGUN,
                      4'd0)};
    plan = {plan, row(chr_pkg::OP_BEGIN,  4'd0,  64'd0, 1'b1, chr_pkg::ST_OK, 4'd0)};
    plan = {plan, row(chr_pkg::OP_BEGIN,  4'd0,  '1,    1'b1, chr_pkg::ST_PRESENT, 4'd0)};
    plan = {plan, row(chr_pkg::OP_BEGIN,  4'd15, 64'd0, 1'b1, chr_pkg::ST_OK, 4'd0)};
    plan = {plan, row(chr_pkg::OP_INSERT, 4'd0,  64'd0, 1'b1, chr_pkg::ST_OK, 4'd0)};
    plan = {plan, row(chr_pkg::OP_INSERT, 4'd15, '1,    1'b1, chr_pkg::ST_OK, 4'd0)};
    plan = {plan, row(chr_pkg::OP_INSERT, 4'd15, 64'h8000_0000_0000_0000, 1'b0,
                      chr_pkg::ST_OK, 4'd0)};
    // Same hash again from another node: it must sort after the first one.
    plan = {plan, row(chr_pkg::OP_INSERT, 4'd0,  64'h8000_0000_0000_0000, 1'b0,
                      chr_pkg::ST_OK, 4'd0)};
    plan = {plan, row(chr_pkg::OP_LOOKUP, 4'd0,  64'd0, 1'b0, chr_pkg::ST_OK, 4'd0)};
    plan = {plan, row(chr_pkg::OP_LOOKUP, 4'd0,  '1,    1'b0, chr_pkg::ST_OK, 4'd0)};
    plan = {plan, row(chr_pkg::OP_LOOKUP, 4'd0,  64'h8000_0000_0000_0000, 1'b0,
                      chr_pkg::ST_OK, 4'd0)};
    plan = {plan, row(chr_pkg::OP_LOOKUP, 4'd0,  64'h7FFF_FFFF_FFFF_FFFF, 1'b0,
                      chr_pkg::ST_OK, 4'd0)};
    plan = {plan, row(chr_pkg::OP_LOOKUP, 4'd0,  64'h8000_0000_0000_0001, 1'b0,
                      chr_pkg::ST_OK, 4'd0)};
    plan = {plan, row(chr_pkg::OP_REMOVE, 4'd15, 64'd0, 1'b1, chr_pkg::ST_OK, 4'd0)};
    plan = {plan, row(chr_pkg::OP_REMOVE, 4'd15, 64'd0, 1'b1, chr_pkg::ST_NONE_FOUND,
                      4'd0)};
    plan = {plan, row(chr_pkg::OP_INSERT, 4'd15, '1,    1'b1, chr_pkg::ST_NOT_BEGUN,
                      4'd0)};
    // Key above every hash wraps around to the first entry.
    plan = {plan, row(chr_pkg::OP_LOOKUP, 4'd0,  '1,    1'b0, chr_pkg::ST_OK, 4'd0)};
    // A begun node with no entries still loses its mark on remove.
    plan = {plan, row(chr_pkg::OP_BEGIN,  4'd9,  64'd0, 1'b1, chr_pkg::ST_OK, 4'd0)};
    plan = {plan, row(chr_pkg::OP_REMOVE, 4'd9,  64'd0, 1'b1, chr_pkg::ST_NONE_FOUND,
                      4'd0)};
    plan = {plan, row(chr_pkg::OP_INSERT, 4'd9,  64'd5, 1'b1, chr_pkg::ST_NOT_BEGUN,
                      4'd0)};
    plan = {plan, row(chr_pkg::OP_REMOVE, 4'd0,  64'd0, 1'b1, chr_pkg::ST_OK, 4'd0)};
    plan = {plan, row(chr_pkg::OP_LOOKUP, 4'd3,  64'h1234, 1'b1, chr_pkg::ST_EMPTY,
                      4'd0)};

    for (int i = 0; i < NODE_COUNT; i++) node_live[i] = 1'b0;

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      d = plan[i];
      send(d.req, d.typed, d.rsp);
    end
    settle();

    rnd = 0;
    while (sent_count < ITEM_TARGET) begin
      calm = (rnd % 2 == 1);
      send_rand(90, 10, 55, 5, 30);
      calm = 1'b0;

      // Fill the ring to capacity, then push past it.
      for (int n = 0; n < NODE_COUNT; n++)
        send(rand_req(1, 0, 0, 0), 1'b0, '0);
      for (int n = 0; n < NODE_COUNT; n++) begin
        d.req.opcode     = chr_pkg::OP_BEGIN;
        d.req.node_index = 4'(n);
        d.req.hash_value = {$urandom, $urandom};
        send(d.req, 1'b0, '0);
      end
      while (ring_count < RING_DEPTH) send(rand_req(0, 1, 0, 0), 1'b0, '0);
      repeat (3) begin
        d.req.opcode     = chr_pkg::OP_INSERT;
        d.req.node_index = pick_node(1'b1);
        d.req.hash_value = pick_hash(1'b0);
        send(d.req, 1'b0, '0);
      end
      send_rand(20, 0, 0, 0, 1);
      settle();

      calm = (rnd % 2 == 0);
      send_rand(150, 20, 30, 20, 30);
      calm = 1'b0;
      settle();

      for (int n = 0; n < NODE_COUNT; n++) begin
        d.req.opcode     = chr_pkg::OP_REMOVE;
        d.req.node_index = 4'(n);
        d.req.hash_value = {$urandom, $urandom};
        send(d.req, 1'b0, '0);
      end
      send_rand(2, 0, 0, 0, 1);
      settle();
      rnd++;
    end

    settle();
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("Covered %0d requests in %0d rounds and checked %0d results.",
             sent_count, rnd, result_count);
    $display("Ring overflowed on %0d inserts; %0d lookups hit an empty ring.",
             full_seen, empty_seen);
    if (fail_count == 0) begin
      $display("PASS consistent_hash_ring_router");
    end else begin
      $display("FAIL consistent_hash_ring_router");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+rtl/core
rtl/core/chr_pkg.sv
rtl/core/chr_datapath.sv
rtl/core/chr_ctrl.sv
rtl/core/consistent_hash_ring_router.sv
verif/tb_consistent_hash_ring_router.sv
